[design/qps_pkg.sv]
// ----------------------------------------------------------------------------
// qps_pkg
// Shared types, codes and helpers for the quadrature position and speed block.
// ----------------------------------------------------------------------------
package qps_pkg;

   localparam int POSITION_WIDTH = 32;
   localparam int OUT_WIDTH      = 32;
   localparam int PIN_WIDTH      = 6;
   localparam int SCALE_WIDTH    = 32;
   localparam int DIV_STEPS      = 32;
   localparam int DIV_CNT_WIDTH  = $clog2(DIV_STEPS);

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN_PIN  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_INTERVAL = 2'd2;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] REG_CHANNEL_A_PIN = 2'd0;
   localparam logic [1:0] REG_CHANNEL_B_PIN = 2'd1;
   localparam logic [1:0] REG_SCALE         = 2'd2;

   localparam logic [PIN_WIDTH-1:0]   CHANNEL_A_RESET = PIN_WIDTH'(0);
   localparam logic [PIN_WIDTH-1:0]   CHANNEL_B_RESET = PIN_WIDTH'(1);
   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET     = SCALE_WIDTH'(65536);

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic edge_commit;
      logic mul;
      logic div_start;
      logic div_step;
      logic tick_commit;
   } qps_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_tick;
      logic in_zero;
      logic rsp_free;
      logic div_last;
   } qps_stat_type;

   // x4 step for index {new_phase, old_phase}
   function automatic logic signed [2:0] step_of(input logic [3:0] idx);
      logic signed [2:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: s = 3'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = -3'sd1;
         4'd3, 4'd12: s = 3'sd2;
         4'd6, 4'd9: s = -3'sd2;
         default: s = 3'sd0;
      endcase
      return s;
   endfunction

   // Sign-extend a counter value, then keep the low output bits
   function automatic logic [OUT_WIDTH-1:0] pos_to_out(input logic [POSITION_WIDTH-1:0] v);
      logic signed [63:0] e;
      e = 64'(signed'(v));
      return e[OUT_WIDTH-1:0];
   endfunction

endpackage

[design/qps_ctrl.sv]
// ----------------------------------------------------------------------------
// qps_ctrl
// Sequencer: takes one request, steps the datapath, waits for the output slot.
// ----------------------------------------------------------------------------
module qps_ctrl import qps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  qps_stat_type stat,
   output qps_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_TICK_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff;
   logic      accept;

   assign req_stall = stall_ff;
   assign accept    = req_valid && !stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (stat.in_tick == OP_TICK) begin
                  state_in = stat.in_zero ? ST_TICK_DONE : ST_MUL;
               end else begin
                  state_in = ST_EDGE;
               end
            end
         end
         ST_EDGE: begin
            if (stat.rsp_free) begin
               cmd.edge_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_TICK_DONE;
            end
         end
         ST_TICK_DONE: begin
            if (stat.rsp_free) begin
               cmd.tick_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the stall flag together
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= (state_in != ST_IDLE);
      end
   end

endmodule

[design/qps_datapath.sv]
// ----------------------------------------------------------------------------
// qps_datapath
// Registers, x4 step table, multiplier, radix-2 divider and output register.
// ----------------------------------------------------------------------------
module qps_datapath import qps_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_operation,
   input  logic [PIN_WIDTH-1:0]          req_pin,
   input  logic                          req_level,
   input  logic [31:0]                   req_interval,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [SCALE_WIDTH-1:0]        csr_data,
   output logic [1:0]                    rsp_status,
   output logic signed [OUT_WIDTH-1:0]   rsp_position,
   output logic signed [OUT_WIDTH-1:0]   rsp_speed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  qps_cmd_type                   cmd,
   output qps_stat_type                  stat
);

   // Configuration
   logic [PIN_WIDTH-1:0]      cha_ff, chb_ff;
   logic [SCALE_WIDTH-1:0]    scale_ff;

   // Encoder state
   logic [1:0]                phase_ff;
   logic [POSITION_WIDTH-1:0] pos_ff, last_ff;

   // Latched request
   logic [PIN_WIDTH-1:0]      pin_ff;
   logic                      level_ff;
   logic [31:0]               interval_ff;

   // Speed arithmetic
   logic                      neg_ff;
   logic [63:0]               product_ff;
   logic                      ovf_ff;
   logic [31:0]               rem_ff;
   logic [31:0]               quo_ff;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff;

   // Output register
   logic                      rsp_valid_ff;
   logic [1:0]                status_ff;
   logic [OUT_WIDTH-1:0]      position_ff, speed_ff;

   logic                      hit_a, hit_b;
   logic [1:0]                newp;
   logic signed [2:0]         step;
   logic [POSITION_WIDTH-1:0] pos_next;
   logic [OUT_WIDTH-1:0]      delta, mag;
   logic [32:0]               trial;
   logic                      trial_ge;
   logic [OUT_WIDTH-1:0]      speed_sat;
   logic                      rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign stat.in_tick  = req_operation;
   assign stat.in_zero  = (req_interval == 32'd0);
   assign stat.rsp_free = rsp_free;
   assign stat.div_last = (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1));

   // Channel A wins when both pin registers match
   assign hit_a    = (pin_ff == cha_ff);
   assign hit_b    = (pin_ff == chb_ff);
   assign newp     = hit_a ? {phase_ff[1], level_ff} : {level_ff, phase_ff[0]};
   assign step     = step_of({newp, phase_ff});
   assign pos_next = pos_ff + POSITION_WIDTH'(step);

   assign delta = pos_to_out(pos_ff - last_ff);
   assign mag   = delta[OUT_WIDTH-1] ? (OUT_WIDTH'(0) - delta) : delta;

   assign trial    = {rem_ff, quo_ff[31]};
   assign trial_ge = (trial >= {1'b0, interval_ff});

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || (quo_ff > 32'h8000_0000)) begin
            speed_sat = 32'h8000_0000;
         end else begin
            speed_sat = 32'd0 - quo_ff;
         end
      end else begin
         if (ovf_ff || quo_ff[31]) begin
            speed_sat = 32'h7FFF_FFFF;
         end else begin
            speed_sat = quo_ff;
         end
      end
   end

   // Configuration and encoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         cha_ff   <= CHANNEL_A_RESET;
         chb_ff   <= CHANNEL_B_RESET;
         scale_ff <= SCALE_RESET;
         phase_ff <= 2'd0;
         pos_ff   <= '0;
         last_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_CHANNEL_A_PIN: cha_ff   <= csr_data[PIN_WIDTH-1:0];
               REG_CHANNEL_B_PIN: chb_ff   <= csr_data[PIN_WIDTH-1:0];
               REG_SCALE:         scale_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.edge_commit && (hit_a || hit_b)) begin
            phase_ff <= newp;
            pos_ff   <= pos_next;
         end
         if (cmd.tick_commit && (interval_ff != 32'd0)) begin
            last_ff <= pos_ff;
         end
      end
   end

   // Request latch and divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pin_ff      <= req_pin;
         level_ff    <= req_level;
         interval_ff <= req_interval;
      end
      if (cmd.mul) begin
         neg_ff     <= delta[OUT_WIDTH-1];
         product_ff <= 64'(mag) * 64'(scale_ff);
      end
      if (cmd.div_start) begin
         ovf_ff <= (product_ff[63:32] >= interval_ff);
         rem_ff <= product_ff[63:32];
         quo_ff <= product_ff[31:0];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? 32'(trial - {1'b0, interval_ff}) : trial[31:0];
         quo_ff <= {quo_ff[30:0], trial_ge};
         cnt_ff <= cnt_ff + DIV_CNT_WIDTH'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.edge_commit || cmd.tick_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_commit) begin
         status_ff   <= (hit_a || hit_b) ? STATUS_OK : STATUS_UNKNOWN_PIN;
         position_ff <= pos_to_out((hit_a || hit_b) ? pos_next : pos_ff);
         speed_ff    <= '0;
      end
      if (cmd.tick_commit) begin
         position_ff <= pos_to_out(pos_ff);
         if (interval_ff == 32'd0) begin
            status_ff <= STATUS_ZERO_INTERVAL;
            speed_ff  <= '0;
         end else begin
            status_ff <= STATUS_OK;
            speed_ff  <= speed_sat;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = signed'(position_ff);
   assign rsp_speed    = signed'(speed_ff);

`ifndef SYNTHESIS
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.edge_commit || cmd.tick_commit) |-> rsp_free)
      else $error("result committed over a waiting result");

   a_last_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !cmd.tick_commit |=> $stable(last_ff))
      else $error("last position moved outside a tick");

   a_pos_only_on_edge: assert property (@(posedge clock) disable iff (reset)
      !cmd.edge_commit |=> $stable(pos_ff))
      else $error("position moved outside a level change");

   a_speed_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_OK)) |-> (speed_ff == '0))
      else $error("non-zero speed on a failed request");
`endif

endmodule

[design/quadrature_position_and_speed.sv]
// ----------------------------------------------------------------------------
// quadrature_position_and_speed
// A level change is latched, then committed once the output slot is free; a
// speed tick goes through multiply, divider set-up, 32 divider steps and
// commit. One request at a time: the next is taken only after the result
// is in the output register; a zero-interval tick skips the arithmetic.
// Reset clears position, last position and phase and restores the registers.
// ----------------------------------------------------------------------------
module quadrature_position_and_speed import qps_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [PIN_WIDTH-1:0]        req_pin,
   input  logic                        req_level,
   input  logic [31:0]                 req_interval,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic signed [OUT_WIDTH-1:0] rsp_position,
   output logic signed [OUT_WIDTH-1:0] rsp_speed,
   // register writes
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [SCALE_WIDTH-1:0]      csr_data
);

   // Commands flow from the sequencer to the datapath; status flows back.
   qps_cmd_type  cmd;
   qps_stat_type stat;

   // The sequencer holds the request channel stalled from acceptance until
   // the result has been placed in the output register. A result may still
   // be waiting downstream while the next request is taken: the output
   // register parts the two sides, and a commit only waits when that
   // register is full and stalled.
   qps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the pin and scale registers, the phase, the wrapping
   // position and the position latched at the last good tick. A level change
   // looks up the x4 step table and updates position in one commit. A tick
   // forms the count difference, takes its magnitude, multiplies by scale,
   // then divides by the interval one quotient bit per cycle; an overflow of
   // the high product word against the interval marks saturation early.
   qps_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_pin          (req_pin),
      .req_level        (req_level),
      .req_interval     (req_interval),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_speed        (rsp_speed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quadrature_position_and_speed: drives level changes
// and speed ticks through the valid/stall channels, applies register writes
// while the block is idle, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module tb import qps_pkg::*; ();

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] position;
      logic [31:0] speed;
   } reading_type;

   // Predicts the x4 decoder and the speed divider, and holds the readings that
   // accepted requests still owe.
   class position_tracker;
      logic [PIN_WIDTH-1:0]   a_pin;
      logic [PIN_WIDTH-1:0]   b_pin;
      logic [SCALE_WIDTH-1:0] scale;
      logic [1:0]             phase;
      logic [31:0]            count;
      logic [31:0]            latched;
      reading_type            due[$];
      int unsigned            errors;

      function new();
         a_pin   = CHANNEL_A_RESET;
         b_pin   = CHANNEL_B_RESET;
         scale   = SCALE_RESET;
         phase   = 2'd0;
         count   = '0;
         latched = '0;
         errors  = 0;
      endfunction

      function void apply_write(logic [1:0] index, logic [31:0] data);
         case (index)
            REG_CHANNEL_A_PIN: a_pin = data[PIN_WIDTH-1:0];
            REG_CHANNEL_B_PIN: b_pin = data[PIN_WIDTH-1:0];
            REG_SCALE:         scale = data;
            default: ;
         endcase
      endfunction

      // Rank the phase along the Gray sequence 00, 01, 11, 10; the count moves
      // against the rank, and a two-place jump goes by the old phase's parity.
      function logic signed [2:0] quad_step(logic [1:0] old_ph, logic [1:0] new_ph);
         logic [1:0] span;
         span = {old_ph[1], ^old_ph} - {new_ph[1], ^new_ph};
         case (span)
            2'd1:    return 3'sd1;
            2'd3:    return -3'sd1;
            2'd2:    return (old_ph[0] == old_ph[1]) ? 3'sd2 : -3'sd2;
            default: return 3'sd0;
         endcase
      endfunction

      // Work on the magnitude, truncate toward zero, then clamp to 32 bits.
      function logic [31:0] speed_of(logic [31:0] delta, logic [31:0] interval);
         logic [63:0] mag;
         logic [63:0] quotient;
         mag = {32'd0, delta[31] ? 32'd0 - delta : delta};
         quotient = mag * {32'd0, scale} / {32'd0, interval};
         if (delta[31]) begin
            if (quotient > 64'h8000_0000) quotient = 64'h8000_0000;
            return 32'd0 - quotient[31:0];
         end
         if (quotient > 64'h7FFF_FFFF) quotient = 64'h7FFF_FFFF;
         return quotient[31:0];
      endfunction

      function void take_request(logic op, logic [PIN_WIDTH-1:0] pin, logic level,
                                 logic [31:0] interval);
         reading_type r;
         logic [1:0]  next_phase;
         r.status = STATUS_OK;
         r.speed  = '0;
         if (op == OP_EDGE) begin
            if (pin != a_pin && pin != b_pin) begin
               r.status = STATUS_UNKNOWN_PIN;
            end else begin
               // channel A wins when both registers hold the same pin
               next_phase = (pin == a_pin) ? {phase[1], level} : {level, phase[0]};
               count = count + 32'(quad_step(phase, next_phase));
               phase = next_phase;
            end
         end else if (interval == 32'd0) begin
            r.status = STATUS_ZERO_INTERVAL;
         end else begin
            r.speed = speed_of(count - latched, interval);
            latched = count;
         end
         r.position = count;
         due.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
         end
      endfunction

      function void check_reading(logic [1:0] status, logic [31:0] position,
                                  logic [31:0] speed);
         reading_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none, actual %0d %0d %0d",
                     $time, status, $signed(position), $signed(speed));
            return;
         end
         want = due.pop_front();
         compare_field("status", 32'(want.status), 32'(status));
         compare_field("position", want.position, position);
         compare_field("speed", want.speed, speed);
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_operation;
   logic [PIN_WIDTH-1:0]        req_pin;
   logic                        req_level;
   logic [31:0]                 req_interval;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [1:0]                  rsp_status;
   logic signed [OUT_WIDTH-1:0] rsp_position;
   logic signed [OUT_WIDTH-1:0] rsp_speed;
   logic                        csr_write_enable;
   logic [1:0]                  csr_index;
   logic [SCALE_WIDTH-1:0]      csr_data;

   position_tracker tracker = new();
   int unsigned     cycle_count = 0;

   // Stimulus-side view of the set-up: which pins are wired as channels,
   // the last level sent on each pin, and the channel to toggle next.
   logic [PIN_WIDTH-1:0] a_pin_now = CHANNEL_A_RESET;
   logic [PIN_WIDTH-1:0] b_pin_now = CHANNEL_B_RESET;
   logic                 pin_level [64];
   bit                   use_b = 1'b1;
   bit                   calm  = 1'b0;

   quadrature_position_and_speed u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_pin          (req_pin),
      .req_level        (req_level),
      .req_interval     (req_interval),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_speed        (rsp_speed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Sample everything at the edge, before this edge's updates land. Register
   // writes go first, then new requests, then results, so a prediction always
   // sees the set-up in force when its request was taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            tracker.apply_write(csr_index, csr_data);
         if (req_valid && !req_stall)
            tracker.take_request(req_operation, req_pin, req_level, req_interval);
         if (rsp_valid && !rsp_stall)
            tracker.check_reading(rsp_status, rsp_position, rsp_speed);
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_interval();
      case ($urandom_range(9))
         0:          return 32'd0;
         1:          return 32'hFFFF_FFFF;
         2, 3, 4, 5: return $urandom_range(1, 2000);
         default:    return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'd65536;
         3:       return $urandom_range(1, 1000);
         default: return $urandom;
      endcase
   endfunction

   // Result side: stall in random bursts, with quiet stretches between.
   initial begin
      int unsigned n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(4) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            n = idle_span();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Present one request, hold it until taken, then pause at random. Keep the
   // payload as it is during the pause; only valid drops.
   task automatic issue(logic op, logic [PIN_WIDTH-1:0] pin, logic level,
                        logic [31:0] interval);
      int unsigned n;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pin       <= pin;
      req_level     <= level;
      req_interval  <= interval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = calm ? 0 : idle_span();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Level change; fill the unused interval with noise.
   task automatic move_pin(logic [PIN_WIDTH-1:0] pin, logic level);
      pin_level[pin] = level;
      issue(OP_EDGE, pin, level, $urandom);
   endtask

   // Speed tick; fill the unused pin and level with noise.
   task automatic sample_speed(logic [31:0] interval);
      issue(OP_TICK, PIN_WIDTH'($urandom_range(53)), 1'($urandom_range(1)), interval);
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_channels(logic [31:0] a_data, logic [31:0] b_data,
                               logic [31:0] scale_data);
      write_register(REG_CHANNEL_A_PIN, a_data);
      write_register(REG_CHANNEL_B_PIN, b_data);
      write_register(REG_SCALE, scale_data);
      a_pin_now = a_data[PIN_WIDTH-1:0];
      b_pin_now = b_data[PIN_WIDTH-1:0];
   endtask

   // Drop valid, wait out every owed reading, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed quadrature: alternate the channels so the count runs
   // one way, toggle the same channel twice to turn round. Mix in ticks,
   // unknown pins and repeated levels.
   task automatic random_phase(int unsigned count);
      int unsigned          roll;
      logic [PIN_WIDTH-1:0] p;
      logic                 lv;
      for (int unsigned i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            sample_speed(pick_interval());
         end else if (roll < 18) begin
            do p = PIN_WIDTH'($urandom_range(53));
            while (p == a_pin_now || p == b_pin_now);
            move_pin(p, 1'($urandom_range(1)));
         end else begin
            if ($urandom_range(7) != 0) use_b = ~use_b;
            p  = use_b ? b_pin_now : a_pin_now;
            lv = ~pin_level[p];
            if ($urandom_range(9) == 0) lv = 1'($urandom_range(1));
            move_pin(p, lv);
         end
      end
   endtask

   initial begin
      logic [31:0] a_word;
      logic [31:0] b_word;
      foreach (pin_level[i]) pin_level[i] = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_EDGE;
      req_pin          <= '0;
      req_level        <= 1'b0;
      req_interval     <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_CHANNEL_A_PIN;
      csr_data         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset set-up: A on pin 0, B on pin 1, unit scale.
      sample_speed(32'd0);             // zero interval, nothing latched
      move_pin(6'd53, 1'b1);           // unknown pin
      move_pin(6'd0, 1'b1);            // one full cycle backwards
      move_pin(6'd1, 1'b1);
      move_pin(6'd0, 1'b0);
      move_pin(6'd1, 1'b0);
      move_pin(6'd1, 1'b0);            // same level again, no movement
      sample_speed(32'd1);
      move_pin(6'd1, 1'b1);            // two counts forwards
      move_pin(6'd0, 1'b1);
      sample_speed(32'hFFFF_FFFF);     // widest interval truncates to zero
      sample_speed(32'd3);             // no movement since last tick

      // Full scale: drive both saturation limits.
      drain();
      set_channels(32'd53, 32'd0, 32'hFFFF_FFFF);
      move_pin(6'd53, 1'b0);
      move_pin(6'd0, 1'b0);
      sample_speed(32'd1);             // clamps to the negative limit
      move_pin(6'd0, 1'b1);
      move_pin(6'd53, 1'b1);
      move_pin(6'd0, 1'b0);
      sample_speed(32'd1);             // clamps to the positive limit
      move_pin(6'd1, 1'b1);            // pin 1 is no longer a channel

      // Both channels on one pin: it counts as A. Zero scale gives no speed.
      drain();
      set_channels(32'd7, 32'd7, 32'd0);
      move_pin(6'd7, 1'b0);
      sample_speed(32'hFFFF_FFFF);

      // Channel pins out of reach, upper data bits set.
      drain();
      set_channels(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1);
      move_pin(6'd53, 1'b1);
      sample_speed(32'd2);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         a_word = $urandom;
         a_word[PIN_WIDTH-1:0] = PIN_WIDTH'($urandom_range(53));
         b_word = $urandom;
         if ($urandom_range(4) == 0)
            b_word[PIN_WIDTH-1:0] = a_word[PIN_WIDTH-1:0];
         else
            b_word[PIN_WIDTH-1:0] = PIN_WIDTH'($urandom_range(53));
         set_channels(a_word, b_word, pick_scale());
         calm = ($urandom_range(3) == 0);
         random_phase(71);
      end

      // Wait for the tail, then keep watching for stray results.
      drain();
      repeat (40) @(posedge clock);
      if (tracker.errors == 0 && tracker.due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: give up well beyond the slowest legal run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
